// File: hdl/fbpa_pkg.sv
`timescale 1ns / 1ps

package fbpa_pkg;

    // Field widths
    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 13;
    localparam int CNT_W   = 9;
    localparam int BYTES_W = 21;
    localparam int STS_W   = 2;

    localparam int DEF_NUM_BLOCKS = 256;

    localparam logic [SIZE_W-1:0] MAX_BLOCK_BYTES = 13'd4096;
    localparam logic [SIZE_W-1:0] DEF_BLOCK_BYTES = 13'd16;
    localparam logic [CNT_W-1:0]  DEF_BLOCK_COUNT = 9'd256;

    typedef logic [STS_W-1:0] status_t;

    localparam status_t STS_OK          = 2'd0;
    localparam status_t STS_NO_BLOCK    = 2'd1;
    localparam status_t STS_OUT_OF_POOL = 2'd2;
    localparam status_t STS_MISALIGNED  = 2'd3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // APB register indexes (paddr[3:2])
    localparam logic [1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [1:0] REG_BLOCK_BYTES = 2'd1;
    localparam logic [1:0] REG_BLOCK_COUNT = 2'd2;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } div_sts_t;

endpackage

// File: hdl/fbpa_req_if.sv
`timescale 1ns / 1ps

interface fbpa_req_if
    import fbpa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, output func, output free_address, input ready);
    modport sink   (input valid, input func, input free_address, output ready);
endinterface

// File: hdl/fbpa_rsp_if.sv
`timescale 1ns / 1ps

interface fbpa_rsp_if
    import fbpa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [STS_W-1:0]   status;
    logic [ADDR_W-1:0]  block_address;
    logic [CNT_W-1:0]   free_blocks;
    logic [BYTES_W-1:0] usage_bytes;
    logic [BYTES_W-1:0] peak_bytes;

    modport source (output valid, output status, output block_address, output free_blocks,
                    output usage_bytes, output peak_bytes, input ready);
    modport sink   (input valid, input status, input block_address, input free_blocks,
                    input usage_bytes, input peak_bytes, output ready);
endinterface

// File: hdl/fbpa_divider.sv
`timescale 1ns / 1ps

module fbpa_divider
    import fbpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [BYTES_W-1:0] dividend,
    input  logic [SIZE_W-1:0]  divisor,
    output logic [BYTES_W-1:0] quotient,
    output div_sts_t           sts
);

    localparam int CW = $clog2(BYTES_W);

    logic [SIZE_W-1:0]  rem_reg;
    logic [SIZE_W-1:0]  rem_next;
    logic [BYTES_W-1:0] quo_reg;
    logic [BYTES_W-1:0] quo_next;
    logic [SIZE_W-1:0]  divisor_reg;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [SIZE_W:0]    trial;
    logic [SIZE_W:0]    diff;
    logic               ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[BYTES_W-1]};
        diff     = trial - {1'b0, divisor_reg};
        ge       = (trial >= {1'b0, divisor_reg});
        rem_next = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
        quo_next = {quo_reg[BYTES_W-2:0], ge};
    end

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(BYTES_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold the operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient     = quo_reg;
    assign sts.done     = done_reg;
    assign sts.rem_zero = (rem_reg == '0);

endmodule

// File: hdl/fbpa_link_ram.sv
`timescale 1ns / 1ps

module fbpa_link_ram
    import fbpa_pkg::*;
#(
    parameter int DEPTH = DEF_NUM_BLOCKS
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [CNT_W-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [CNT_W-1:0]         rdata
);

    logic [CNT_W-1:0] mem [DEPTH];
    logic [CNT_W-1:0] rdata_reg;

    // Write one link, read one link with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/fixed_block_pool_allocator.sv
`timescale 1ns / 1ps

// Channel    Dir  Handshake       Word
// req        in   valid/ready     func, free_address
// rsp        out  valid/ready     status, block_address, free_blocks, usage_bytes, peak_bytes
// apb        in   psel/penable    pool_base, block_bytes, block_count
//
// Allocate: the word passes ST_ALLOC, ST_ALLOC_WB and ST_DONE, skipping ST_ALLOC_WB
// on an empty list; ST_ALLOC_WB takes the next head from the registered link RAM read.
// Free: the word passes ST_FREE_CHK, ST_FREE_DIV and ST_DONE, skipping ST_FREE_DIV when
// outside the pool; ST_FREE_DIV waits for the 21-step restoring divider. ST_IDLE accepts
// the next word once the result is in the output register. After reset and after every
// register write the link RAM is rebuilt, one entry per cycle, with req.ready low meanwhile.
// A finished word waits in the output register while rsp.ready is low.

module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int NUM_BLOCKS = DEF_NUM_BLOCKS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    fbpa_req_if.sink    req,
    fbpa_rsp_if.source  rsp
);

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int MW = CNT_W + SIZE_W;

    localparam logic [2:0] ST_CLEAR     = 3'd0;
    localparam logic [2:0] ST_IDLE      = 3'd1;
    localparam logic [2:0] ST_ALLOC     = 3'd2;
    localparam logic [2:0] ST_ALLOC_WB  = 3'd3;
    localparam logic [2:0] ST_FREE_CHK  = 3'd4;
    localparam logic [2:0] ST_FREE_DIV  = 3'd5;
    localparam logic [2:0] ST_DONE      = 3'd6;

    // Configuration registers
    logic [ADDR_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  bytes_reg;
    logic [CNT_W-1:0]   range_reg;

    logic [2:0]         state_reg;
    logic [AW-1:0]      sweep_reg;
    logic [CNT_W-1:0]   head_reg;
    logic [CNT_W-1:0]   used_reg;
    logic [CNT_W-1:0]   peak_used_reg;
    logic [BYTES_W-1:0] usage_reg;
    logic [BYTES_W-1:0] peak_bytes_reg;

    logic               func_reg;
    logic [ADDR_W-1:0]  faddr_reg;
    logic [BYTES_W-1:0] pool_bytes_reg;
    logic [BYTES_W-1:0] offset_reg;
    status_t            res_status_reg;
    logic [ADDR_W-1:0]  res_addr_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [CNT_W-1:0]   out_free_reg;
    logic [BYTES_W-1:0] out_usage_reg;
    logic [BYTES_W-1:0] out_peak_reg;

    logic               cfg_wr;
    logic               cfg_hit;
    logic [1:0]         cfg_idx;
    logic [SIZE_W-1:0]  size_eff;
    logic [CNT_W-1:0]   count_eff;
    logic [CNT_W-1:0]   mul_a;
    logic [MW-1:0]      mul_full;
    logic [BYTES_W-1:0] product;
    logic [ADDR_W-1:0]  free_off;
    logic               in_pool;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [CNT_W-1:0]   ram_wdata;
    logic [CNT_W-1:0]   ram_rdata;

    logic               div_start;
    logic [BYTES_W-1:0] div_quo;
    div_sts_t           div_sts;
    logic [CNT_W-1:0]   free_idx;
    logic               free_push;

    logic               accept;
    logic               load_out;
    logic [CNT_W-1:0]   used_inc;
    logic [BYTES_W-1:0] usage_inc;

    // APB decode
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_hit = cfg_wr && (cfg_idx == REG_POOL_BASE || cfg_idx == REG_BLOCK_BYTES
                                || cfg_idx == REG_BLOCK_COUNT);

    always_comb
    begin
        case (cfg_idx)
            REG_POOL_BASE:   prdata = base_reg;
            REG_BLOCK_BYTES: prdata = {{(32 - SIZE_W){1'b0}}, bytes_reg};
            REG_BLOCK_COUNT: prdata = {{(32 - CNT_W){1'b0}}, range_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            bytes_reg <= DEF_BLOCK_BYTES;
            range_reg <= DEF_BLOCK_COUNT;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_POOL_BASE:   base_reg  <= pwdata;
                REG_BLOCK_BYTES: bytes_reg <= pwdata[SIZE_W-1:0];
                REG_BLOCK_COUNT: range_reg <= pwdata[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Clamp size and count to their legal ranges
    always_comb
    begin
        if (bytes_reg == '0)
            size_eff = SIZE_W'(1);
        else if (bytes_reg > MAX_BLOCK_BYTES)
            size_eff = MAX_BLOCK_BYTES;
        else
            size_eff = bytes_reg;

        if (range_reg == '0)
            count_eff = CNT_W'(1);
        else if (32'(range_reg) > 32'(NUM_BLOCKS))
            count_eff = CNT_W'(NUM_BLOCKS);
        else
            count_eff = range_reg;
    end

    // Shared multiplier: pool size while rebuilding, block offset on allocate
    assign mul_a    = (state_reg == ST_CLEAR) ? count_eff : head_reg;
    assign mul_full = MW'(mul_a) * MW'(size_eff);
    assign product  = mul_full[BYTES_W-1:0];

    // Free range check
    assign free_off = faddr_reg - base_reg;
    assign in_pool  = (faddr_reg >= base_reg)
                      && (free_off < {{(ADDR_W - BYTES_W){1'b0}}, pool_bytes_reg});

    // Divider hookup
    assign div_start = (state_reg == ST_FREE_CHK) && in_pool;
    assign free_idx  = div_quo[CNT_W-1:0];
    assign free_push = (state_reg == ST_FREE_DIV) && div_sts.done && div_sts.rem_zero;

    fbpa_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (free_off[BYTES_W-1:0]),
        .divisor  (size_eff),
        .quotient (div_quo),
        .sts      (div_sts)
    );

    // Link RAM: sweep writes i+1, free pushes the old head
    assign ram_we    = (state_reg == ST_CLEAR) || free_push;
    assign ram_waddr = (state_reg == ST_CLEAR) ? sweep_reg : AW'(free_idx);
    assign ram_wdata = (state_reg == ST_CLEAR) ? CNT_W'(32'(sweep_reg) + 32'd1) : head_reg;

    fbpa_link_ram #(
        .DEPTH (NUM_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (AW'(head_reg)),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);
    assign used_inc  = used_reg + 1'b1;
    assign usage_inc = usage_reg + BYTES_W'(size_eff);

    // Sequencer and allocator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            sweep_reg      <= '0;
            head_reg       <= '0;
            used_reg       <= '0;
            peak_used_reg  <= '0;
            usage_reg      <= '0;
            peak_bytes_reg <= '0;
        end
        else if (cfg_hit)
        begin
            state_reg <= ST_CLEAR;
            sweep_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    head_reg       <= '0;
                    used_reg       <= '0;
                    peak_used_reg  <= '0;
                    usage_reg      <= '0;
                    peak_bytes_reg <= '0;
                    sweep_reg      <= sweep_reg + 1'b1;
                    if (sweep_reg == AW'(NUM_BLOCKS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= (req.func == FUNC_ALLOC) ? ST_ALLOC : ST_FREE_CHK;
                    end
                end
                ST_ALLOC:
                begin
                    state_reg <= (head_reg >= count_eff) ? ST_DONE : ST_ALLOC_WB;
                end
                ST_ALLOC_WB:
                begin
                    head_reg <= ram_rdata;
                    if (used_reg < count_eff)
                    begin
                        used_reg  <= used_inc;
                        usage_reg <= usage_inc;
                        if (used_inc > peak_used_reg)
                        begin
                            peak_used_reg  <= used_inc;
                            peak_bytes_reg <= usage_inc;
                        end
                    end
                    state_reg <= ST_DONE;
                end
                ST_FREE_CHK:
                begin
                    state_reg <= in_pool ? ST_FREE_DIV : ST_DONE;
                end
                ST_FREE_DIV:
                begin
                    if (div_sts.done)
                    begin
                        if (div_sts.rem_zero)
                        begin
                            head_reg <= free_idx;
                            if (used_reg != '0)
                            begin
                                used_reg  <= used_reg - 1'b1;
                                usage_reg <= usage_reg - BYTES_W'(size_eff);
                            end
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Operation payload and pending result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg       <= req.func;
            faddr_reg      <= req.free_address;
            res_status_reg <= STS_OK;
            res_addr_reg   <= '0;
        end
        if (state_reg == ST_CLEAR)
        begin
            pool_bytes_reg <= product;
        end
        if (state_reg == ST_ALLOC)
        begin
            offset_reg <= product;
            if (head_reg >= count_eff)
            begin
                res_status_reg <= STS_NO_BLOCK;
            end
        end
        if (state_reg == ST_ALLOC_WB)
        begin
            res_addr_reg <= base_reg + {{(ADDR_W - BYTES_W){1'b0}}, offset_reg};
        end
        if (state_reg == ST_FREE_CHK && !in_pool)
        begin
            res_status_reg <= STS_OUT_OF_POOL;
        end
        if (state_reg == ST_FREE_DIV && div_sts.done && !div_sts.rem_zero)
        begin
            res_status_reg <= STS_MISALIGNED;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= (func_reg == FUNC_ALLOC) ? res_addr_reg : '0;
            out_free_reg   <= count_eff - used_reg;
            out_usage_reg  <= usage_reg;
            out_peak_reg   <= peak_bytes_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.block_address = out_addr_reg;
    assign rsp.free_blocks   = out_free_reg;
    assign rsp.usage_bytes   = out_usage_reg;
    assign rsp.peak_bytes    = out_peak_reg;

endmodule
